@@ hdl/hvvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvvt_pkg
// shared types and constants of the vertex viewport transform
// ----------------------------------------------------------------------------
package hvvt_pkg;

    localparam int DATA_W     = 32;
    localparam int DEN_W      = 32;
    localparam int TDATA_W    = 160;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ROW     = 3'd0,
        REG_Y_ROW     = 3'd1,
        REG_W_ROW     = 3'd2,
        REG_XY_TRANS  = 3'd3,
        REG_W_TRANS   = 3'd4,
        REG_WIN_WIDTH = 3'd5,
        REG_WIN_HGT   = 3'd6
    } cfg_reg_t;

endpackage : hvvt_pkg
`default_nettype wire

@@ hdl/homogeneous_vertex_viewport_transform.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_vertex_viewport_transform
// sprite vertex projection, perspective divide and window mapping
// ----------------------------------------------------------------------------
// input beats on s_* carry one vertex each; output beats on m_* carry the
// window position, the texture coordinates and the color, passed through as is.
// cfg_* writes one matrix or window register per beat and is always ready;
// write it only while no vertex is in flight.
// the divider resolves one quotient bit per stage. throughput is one vertex
// per cycle unless the output stalls; every stage holds a valid bit.
// when m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// reset empties the pipeline and loads the identity projection with w = 1
// and a 1024 x 768 window.
// ----------------------------------------------------------------------------
module homogeneous_vertex_viewport_transform
    import hvvt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // vertex_x, vertex_y, tex_u, tex_v, color_abgr
    input  wire logic [TDATA_W-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_x, pixel_y, out_tex_u, out_tex_v, red, green, blue, alpha
    output logic      [TDATA_W-1:0]    m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QW = DATA_W + FRAC_BITS;
    localparam int SB_W = 2 + 3 * DATA_W;
    localparam logic signed [DATA_W:0] ONE_FX = (DATA_W+1)'(1) <<< FRAC_BITS;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi)
            return DATA_W'(hi);
        else if (v < lo)
            return DATA_W'(lo);
        else
            return v[DATA_W-1:0];
    endfunction

    // configuration registers
    logic [63:0]        x_row_reg;
    logic [63:0]        y_row_reg;
    logic [63:0]        w_row_reg;
    logic [63:0]        xy_trans_reg;
    logic [31:0]        w_trans_reg;
    logic [15:0]        win_w_reg;
    logic [15:0]        win_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_row_reg    <= 64'd65536;
            y_row_reg    <= 64'd281474976710656;
            w_row_reg    <= '0;
            xy_trans_reg <= '0;
            w_trans_reg  <= 32'd65536;
            win_w_reg    <= 16'd1024;
            win_h_reg    <= 16'd768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_ROW:     x_row_reg    <= cfg_data;
                REG_Y_ROW:     y_row_reg    <= cfg_data;
                REG_W_ROW:     w_row_reg    <= cfg_data;
                REG_XY_TRANS:  xy_trans_reg <= cfg_data;
                REG_W_TRANS:   w_trans_reg  <= cfg_data[31:0];
                REG_WIN_WIDTH: win_w_reg    <= cfg_data[15:0];
                REG_WIN_HGT:   win_h_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // global advance
    logic ce;
    logic out_vld_reg;
    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;

    // stage 1: six products
    logic                      s1_vld_reg;
    logic signed [63:0]        pxx_reg, pxy_reg, pyx_reg, pyy_reg, pwx_reg, pwy_reg;
    logic [3*DATA_W-1:0]       s1_pay_reg;

    logic signed [DATA_W-1:0]  in_x, in_y;
    assign in_x = s_tdata[31:0];
    assign in_y = s_tdata[63:32];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pxx_reg    <= $signed(x_row_reg[31:0])  * in_x;
            pxy_reg    <= $signed(x_row_reg[63:32]) * in_y;
            pyx_reg    <= $signed(y_row_reg[31:0])  * in_x;
            pyy_reg    <= $signed(y_row_reg[63:32]) * in_y;
            pwx_reg    <= $signed(w_row_reg[31:0])  * in_x;
            pwy_reg    <= $signed(w_row_reg[63:32]) * in_y;
            s1_pay_reg <= s_tdata[159:64];
        end
    end

    // stage 2: row sums with floor, translation and saturation
    logic                     s2_vld_reg;
    logic signed [DATA_W-1:0] bx_reg, by_reg, bw_reg;
    logic [3*DATA_W-1:0]      s2_pay_reg;
    logic signed [64:0]       sum_x, sum_y, sum_w;
    logic signed [65:0]       tot_x, tot_y, tot_w;

    always_comb
    begin
        sum_x = 65'(pxx_reg) + 65'(pxy_reg);
        sum_y = 65'(pyx_reg) + 65'(pyy_reg);
        sum_w = 65'(pwx_reg) + 65'(pwy_reg);
        tot_x = 66'(sum_x >>> FRAC_BITS) + 66'($signed(xy_trans_reg[31:0]));
        tot_y = 66'(sum_y >>> FRAC_BITS) + 66'($signed(xy_trans_reg[63:32]));
        tot_w = 66'(sum_w >>> FRAC_BITS) + 66'($signed(w_trans_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            bx_reg     <= sat32(72'(tot_x));
            by_reg     <= sat32(72'(tot_y));
            bw_reg     <= sat32(72'(tot_w));
            s2_pay_reg <= s1_pay_reg;
        end
    end

    // stage 3: magnitudes and signs for the divider; zero w divides by one
    logic                 s3_vld_reg;
    logic [QW-1:0]        s3_nx_reg, s3_ny_reg;
    logic [DEN_W-1:0]     s3_den_reg;
    logic [SB_W-1:0]      s3_sb_reg;
    logic [DATA_W-1:0]    abs_x, abs_y, abs_w;

    always_comb
    begin
        abs_x = bx_reg[DATA_W-1] ? DATA_W'(-bx_reg) : DATA_W'(bx_reg);
        abs_y = by_reg[DATA_W-1] ? DATA_W'(-by_reg) : DATA_W'(by_reg);
        abs_w = bw_reg[DATA_W-1] ? DATA_W'(-bw_reg) : DATA_W'(bw_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s3_nx_reg  <= {abs_x, {FRAC_BITS{1'b0}}};
            s3_ny_reg  <= {abs_y, {FRAC_BITS{1'b0}}};
            s3_den_reg <= (bw_reg == '0) ? DEN_W'(ONE_FX) : abs_w;
            s3_sb_reg  <= {s2_pay_reg,
                           by_reg[DATA_W-1] ^ bw_reg[DATA_W-1],
                           bx_reg[DATA_W-1] ^ bw_reg[DATA_W-1]};
        end
    end

    logic [QW-1:0] qx, qy;

    hvvt_div #(.QW(QW)) u_div_x
    (
        .clk (clk),
        .ce  (ce),
        .num (s3_nx_reg),
        .den (s3_den_reg),
        .quo (qx)
    );

    hvvt_div #(.QW(QW)) u_div_y
    (
        .clk (clk),
        .ce  (ce),
        .num (s3_ny_reg),
        .den (s3_den_reg),
        .quo (qy)
    );

    // sideband and valid bits follow the divider stages
    logic [SB_W-1:0] sb_reg  [QW];
    logic [QW-1:0]   dvld_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sb_reg[0] <= s3_sb_reg;
            for (int i = 1; i < QW; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // stage: signed, saturated ndc
    logic                     ndc_vld_reg;
    logic signed [DATA_W-1:0] ndc_x_reg, ndc_y_reg;
    logic [3*DATA_W-1:0]      ndc_pay_reg;
    logic [SB_W-1:0]          sb_last;

    assign sb_last = sb_reg[QW-1];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ndc_x_reg   <= sat32(sb_last[0] ? -$signed(72'(qx)) : $signed(72'(qx)));
            ndc_y_reg   <= sat32(sb_last[1] ? -$signed(72'(qy)) : $signed(72'(qy)));
            ndc_pay_reg <= sb_last[SB_W-1:2];
        end
    end

    // stage: viewport products
    logic                 vp_vld_reg;
    logic signed [49:0]   vpx_reg, vpy_reg;
    logic [3*DATA_W-1:0]  vp_pay_reg;
    logic signed [DATA_W:0] ax, ay;

    always_comb
    begin
        ax = (DATA_W+1)'(ndc_x_reg) + ONE_FX;
        ay = ONE_FX - (DATA_W+1)'(ndc_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vpx_reg    <= ax * $signed({1'b0, win_w_reg});
            vpy_reg    <= ay * $signed({1'b0, win_h_reg});
            vp_pay_reg <= ndc_pay_reg;
        end
    end

    // output register: halve with floor and saturate
    logic [TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
            out_data_reg <= {vp_pay_reg,
                             sat32(72'(vpy_reg >>> 1)),
                             sat32(72'(vpx_reg >>> 1))};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dvld_reg    <= '0;
            ndc_vld_reg <= 1'b0;
            vp_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            s1_vld_reg  <= s_tvalid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            dvld_reg    <= {dvld_reg[QW-2:0], s3_vld_reg};
            ndc_vld_reg <= dvld_reg[QW-1];
            vp_vld_reg  <= ndc_vld_reg;
            out_vld_reg <= vp_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable({s1_vld_reg, dvld_reg, out_vld_reg}))
        else $error("pipeline moved during a stall");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> (s3_den_reg != '0))
        else $error("divider fed a zero divisor");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_vld_reg)
        else $error("accepted beat not captured");

endmodule : homogeneous_vertex_viewport_transform
`default_nettype wire

@@ hdl/hvvt_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvvt_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module hvvt_div
    import hvvt_pkg::*;
#(
    parameter int QW = 48
)
(
    input  wire logic             clk,
    input  wire logic             ce,
    input  wire logic [QW-1:0]    num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QW-1:0]    quo
);

    logic [DEN_W-1:0] rem_reg [QW];
    logic [QW-1:0]    nq_reg  [QW];
    logic [DEN_W-1:0] den_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QW-1:0]    nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             fits;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // shift in the next dividend bit and try the subtract
        assign trial = {rem_in, nq_in[QW-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                nq_reg[i]  <= {nq_in[QW-2:0], fits};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = nq_reg[QW-1];

endmodule : hvvt_div
`default_nettype wire
